@@ sv/gpio_eic_pkg.sv @@
// Shared types and constants for the GPIO edge interrupt controller.
package gpio_eic_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned PinW    = 5;
  localparam int unsigned PinCount = 32;

  // Bit b stands for pin 31-b, so the implemented pins occupy the top bits.
  localparam logic [WordW-1:0] ImplMask = {WordW{1'b1}} << (WordW - PinCount);
  localparam logic [PinW-1:0]  TopPin   = PinW'(WordW - 1);

  typedef enum logic [1:0] {
    OpSample = 2'd0,
    OpRead   = 2'd1,
    OpWrite  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    SelEvent = 2'd0,
    SelMask  = 2'd1,
    SelEdge  = 2'd2
  } sel_e;

endpackage

@@ sv/gpio_edge_interrupt_controller_top.sv @@
// An input transfer passes through the input register, then the result register.
// Throughput: one item per cycle unless out_stall_i holds a full result register; each item
// is a single pass of bitwise logic and one priority encoder between the two registers.
// Reset: rst_ni clears the event, mask, edge-control and last-level registers and
// both valid flags at once; the block takes items in the first cycle after reset.
module gpio_edge_interrupt_controller_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     operation_i,
  input  logic [1:0]                     reg_select_i,
  input  logic [gpio_eic_pkg::WordW-1:0] write_data_i,
  input  logic [gpio_eic_pkg::WordW-1:0] pin_levels_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gpio_eic_pkg::WordW-1:0] read_data_o,
  output logic                           irq_o,
  output logic                           pending_valid_o,
  output logic [gpio_eic_pkg::PinW-1:0]  next_pin_o
);
  import gpio_eic_pkg::*;

  // Input register.
  logic             in_valid_q;
  logic [1:0]       op_q;
  logic [1:0]       sel_q;
  logic [WordW-1:0] wdata_q;
  logic [WordW-1:0] pins_q;

  // Block state.
  logic [WordW-1:0] event_q, event_d;
  logic [WordW-1:0] mask_q, mask_d;
  logic [WordW-1:0] edge_q, edge_d;
  logic [WordW-1:0] last_q, last_d;

  // Result register.
  logic             out_valid_q;
  logic [WordW-1:0] rdata_q, rdata_d;
  logic             irq_q, pvalid_q;
  logic [PinW-1:0]  pin_q;

  logic             adv;
  logic [WordW-1:0] changed, falling, hits, pending_d;
  logic             hit_d;
  logic [PinW-1:0]  pin_d;

  // The held item moves into the result register when that slot is free or drains now.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q    <= operation_i;
      sel_q   <= reg_select_i;
      wdata_q <= write_data_i;
      pins_q  <= pin_levels_i;
    end
  end

  always_comb begin
    event_d = event_q;
    mask_d  = mask_q;
    edge_d  = edge_q;
    last_d  = last_q;
    rdata_d = '0;
    changed = last_q ^ pins_q;
    falling = last_q & ~pins_q;
    hits    = (edge_q & falling) | (~edge_q & changed);
    case (op_e'(op_q))
      OpSample: begin
        event_d = (event_q | hits) & ImplMask;
        last_d  = pins_q;
      end
      OpRead: begin
        case (sel_e'(sel_q))
          SelEvent: rdata_d = event_q & ImplMask;
          SelMask:  rdata_d = mask_q & ImplMask;
          SelEdge:  rdata_d = edge_q & ImplMask;
          default:  rdata_d = '0;
        endcase
      end
      OpWrite: begin
        case (sel_e'(sel_q))
          SelEvent: event_d = event_q & ~wdata_q & ImplMask;
          SelMask:  mask_d  = wdata_q & ImplMask;
          SelEdge:  edge_d  = wdata_q & ImplMask;
          default:  ;
        endcase
      end
      default: ;
    endcase
    pending_d = event_d & mask_d & ImplMask;
  end

  gpio_eic_penc u_penc (
    .pending_i (pending_d),
    .hit_o     (hit_d),
    .pin_o     (pin_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_q     <= '0;
      mask_q      <= '0;
      edge_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        event_q <= event_d;
        mask_q  <= mask_d;
        edge_q  <= edge_d;
        last_q  <= last_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q  <= rdata_d;
      irq_q    <= hit_d;
      pvalid_q <= hit_d;
      pin_q    <= pin_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rdata_q;
  assign irq_o           = irq_q;
  assign pending_valid_o = pvalid_q;
  assign next_pin_o      = pin_q;

`ifndef ASSERT_OFF
  // Nothing is recorded for pins that are not implemented.
  a_event_impl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_q & ~ImplMask) == '0)
    else $error("event bit set for an unimplemented pin");

  // State only changes when an item moves into the result register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(event_q) && $stable(mask_q) && $stable(edge_q) && $stable(last_q)))
    else $error("state changed without a transfer into the result register");

  // A freshly loaded result names a pin that is pending in the new state.
  a_pin_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(adv) && pending_valid_o) |->
      |(event_q & mask_q & ({1'b1, {(WordW-1){1'b0}}} >> next_pin_o)))
    else $error("next pin is not pending");

  // With nothing pending, the pin number and the interrupt are both zero.
  a_idle_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pending_valid_o) |-> (next_pin_o == '0 && !irq_o))
    else $error("pin number or interrupt set with nothing pending");
`endif

endmodule

@@ sv/gpio_eic_penc.sv @@
// Priority encoder that finds the lowest pending bit and returns its pin number.
module gpio_eic_penc (
  input  logic [gpio_eic_pkg::WordW-1:0] pending_i,
  output logic                           hit_o,
  output logic [gpio_eic_pkg::PinW-1:0]  pin_o
);
  import gpio_eic_pkg::*;

  logic [PinW-1:0] idx;

  always_comb begin
    idx = '0;
    // Scan from the top so that the lowest set bit is the last one written.
    for (int i = WordW - 1; i >= 0; i--) begin
      if (pending_i[i]) begin
        idx = PinW'(i);
      end
    end
  end

  assign hit_o = |pending_i;
  assign pin_o = hit_o ? (TopPin - idx) : '0;

endmodule

@@ verif/gpio_edge_interrupt_controller_top_tb.sv @@
// Self-checking testbench for the GPIO edge interrupt controller with random idling.
`timescale 1ns / 1ps

module gpio_edge_interrupt_controller_top_tb;
  import gpio_eic_pkg::*;

  localparam logic [1:0] OpNone      = 2'd3;
  localparam logic [1:0] SelNone     = 2'd3;
  localparam int unsigned RandomItems = 1600;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [WordW-1:0] AllOnes = '1;

  typedef struct packed {
    logic [WordW-1:0] read_data;
    logic             irq;
    logic             pending_valid;
    logic [PinW-1:0]  next_pin;
  } gpio_result_t;

  class irq_scoreboard;
    logic [WordW-1:0] events;
    logic [WordW-1:0] enables;
    logic [WordW-1:0] falling_only;
    logic [WordW-1:0] prev_levels;
    gpio_result_t     expected_q[$];
    int unsigned      errors;

    function new();
      events       = '0;
      enables      = '0;
      falling_only = '0;
      prev_levels  = '0;
      errors       = 0;
    endfunction

    function int unsigned pending_count();
      return expected_q.size();
    endfunction

    // Updates the register copy for one accepted input transfer and queues its result.
    function void note_transfer(logic [1:0] op, logic [1:0] sel, logic [WordW-1:0] wdata,
                                logic [WordW-1:0] pins);
      logic [WordW-1:0] hits;
      logic [WordW-1:0] pend;
      gpio_result_t     res;
      res = '0;
      case (op)
        OpSample: begin
          hits = (falling_only & prev_levels & ~pins) | (~falling_only & (prev_levels ^ pins));
          events = (events | hits) & ImplMask;
          prev_levels = pins;
        end
        OpRead: begin
          case (sel)
            SelEvent: res.read_data = events;
            SelMask:  res.read_data = enables;
            SelEdge:  res.read_data = falling_only;
            default:  res.read_data = '0;
          endcase
          res.read_data = res.read_data & ImplMask;
        end
        OpWrite: begin
          case (sel)
            SelEvent: events = events & ~wdata & ImplMask;
            SelMask:  enables = wdata & ImplMask;
            SelEdge:  falling_only = wdata & ImplMask;
            default:  ;
          endcase
        end
        default: ;
      endcase
      pend = events & enables & ImplMask;
      res.irq = |pend;
      res.pending_valid = |pend;
      // Walk down so that the lowest set bit is the one that sticks.
      for (int i = WordW - 1; i >= 0; i--) begin
        if (pend[i]) res.next_pin = TopPin - PinW'(i);
      end
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(gpio_result_t got);
      gpio_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("irq", WordW'(want.irq), WordW'(got.irq));
      compare_field("pending_valid", WordW'(want.pending_valid), WordW'(got.pending_valid));
      compare_field("next_pin", WordW'(want.next_pin), WordW'(got.next_pin));
    endfunction
  endclass

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_stall_o;
  logic [1:0]       operation_i     = '0;
  logic [1:0]       reg_select_i    = '0;
  logic [WordW-1:0] write_data_i    = '0;
  logic [WordW-1:0] pin_levels_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i     = 1'b0;
  logic [WordW-1:0] read_data_o;
  logic             irq_o;
  logic             pending_valid_o;
  logic [PinW-1:0]  next_pin_o;

  bit             quiet = 1'b0;
  int unsigned    cycle_count;
  irq_scoreboard  board;

  gpio_edge_interrupt_controller_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .reg_select_i    (reg_select_i),
    .write_data_i    (write_data_i),
    .pin_levels_i    (pin_levels_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .irq_o           (irq_o),
    .pending_valid_o (pending_valid_o),
    .next_pin_o      (next_pin_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short idle stretches with an occasional long one.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Results are checked before the input of the same edge is noted, so the queue order holds.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      board.check_result(gpio_result_t'({read_data_o, irq_o, pending_valid_o, next_pin_o}));
    if (in_valid_i && !in_stall_o)
      board.note_transfer(operation_i, reg_select_i, write_data_i, pin_levels_i);
  end

  initial begin
    bit          stalling;
    int unsigned run;
    stalling = 1'b0;
    run = 0;
    forever begin
      @(posedge clk_i);
      if (run == 0) begin
        if (quiet) begin
          stalling = 1'b0;
          run = 16;
        end else begin
          stalling = !stalling;
          run = stalling ? pick_idle() + 1 : $urandom_range(1, 12);
        end
      end
      out_stall_i <= stalling;
      run--;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Returns at the edge where the transfer is taken, so the next item can be driven there.
  task automatic send_item(logic [1:0] op, logic [1:0] sel, logic [WordW-1:0] wdata,
                           logic [WordW-1:0] pins);
    int unsigned gap;
    gap = quiet ? 0 : pick_idle();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    reg_select_i <= sel;
    write_data_i <= wdata;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int unsigned      r;
    logic [WordW-1:0] levels;
    logic [WordW-1:0] word;
    logic [1:0]       sel;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values, then the first sample, where every high pin counts as a rising edge.
    send_item(OpRead, SelEvent, $urandom(), $urandom());
    send_item(OpRead, SelMask, $urandom(), $urandom());
    send_item(OpRead, SelEdge, $urandom(), $urandom());
    send_item(OpSample, SelEvent, $urandom(), AllOnes);
    send_item(OpRead, SelEvent, '0, '0);
    // Walk the pending pin from the lowest bit up to the top one.
    send_item(OpWrite, SelMask, AllOnes, $urandom());
    send_item(OpWrite, SelEvent, 32'h0000_0001, '0);
    send_item(OpWrite, SelEvent, 32'h7fff_fffe, AllOnes);
    send_item(OpWrite, SelEvent, AllOnes, '0);
    // Falling-edge-only arming.
    send_item(OpWrite, SelEdge, AllOnes, '0);
    send_item(OpSample, SelMask, AllOnes, '0);
    send_item(OpWrite, SelEvent, AllOnes, AllOnes);
    send_item(OpSample, SelEdge, '0, AllOnes);
    send_item(OpRead, SelEvent, '0, '0);
    send_item(OpWrite, SelEdge, '0, '0);
    send_item(OpSample, SelEvent, '0, 32'ha5a5_a5a5);
    // Unused operation and unused register select leave everything alone and read zero.
    send_item(OpNone, SelEvent, AllOnes, 32'h5a5a_5a5a);
    send_item(OpWrite, SelNone, AllOnes, AllOnes);
    send_item(OpRead, SelNone, AllOnes, AllOnes);
    send_item(OpWrite, SelMask, 32'h8000_0000, AllOnes);
    send_item(OpWrite, SelEdge, 32'h5555_5555, '0);
    send_item(OpSample, SelEvent, AllOnes, 32'h5a5a_5a5a);
    send_item(OpRead, SelEdge, '0, AllOnes);
    send_item(OpRead, SelMask, '0, '0);
    send_item(OpRead, SelEvent, AllOnes, '0);
    levels = 32'h5a5a_5a5a;

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        case ($urandom_range(0, 4))
          0: levels = $urandom();
          1: levels = levels ^ (32'h1 << $urandom_range(0, 31));
          2: levels = levels ^ ($urandom() & $urandom() & $urandom());
          3: levels = $urandom_range(0, 1) ? AllOnes : '0;
          default: ;
        endcase
        send_item(OpSample, 2'($urandom_range(0, 3)), $urandom(), levels);
      end else if (r < 62) begin
        send_item(OpRead, 2'($urandom_range(0, 3)), $urandom(), $urandom());
      end else if (r < 90) begin
        sel = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
          0: word = $urandom();
          1: word = $urandom() & $urandom();
          2: word = 32'h1 << $urandom_range(0, 31);
          default: word = $urandom_range(0, 1) ? AllOnes : '0;
        endcase
        send_item(OpWrite, sel, word, $urandom());
      end else if (r < 95) begin
        send_item(OpNone, 2'($urandom_range(0, 3)), $urandom(), $urandom());
      end else begin
        send_item(2'($urandom_range(1, 2)), SelNone, $urandom(), $urandom());
      end
    end
    in_valid_i <= 1'b0;

    // One more edge so that the last transfer is noted before the queue is polled.
    @(posedge clk_i);
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending_count() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gpio_eic_pkg.sv
sv/gpio_eic_penc.sv
sv/gpio_edge_interrupt_controller_top.sv
verif/gpio_edge_interrupt_controller_top_tb.sv
